// ----- src/vtf_pkg.sv -----
package vtf_pkg;

  // grid and list geometry
  localparam int GRID      = 16;
  localparam int MAX_CAMS  = 8;
  localparam int VOX_W     = 4;
  localparam int AXIS_W    = $clog2(GRID);
  localparam int VOX_AW    = 3 * AXIS_W;
  localparam int NVOX      = GRID * GRID * GRID;
  localparam int SLOT_W    = (MAX_CAMS > 1) ? $clog2(MAX_CAMS) : 1;
  localparam int LEN_W     = $clog2(MAX_CAMS + 1);
  localparam int LIST_AW   = VOX_AW + SLOT_W;
  localparam int NLIST     = 1 << LIST_AW;

  // field widths
  localparam int CAM_W     = 10;
  localparam int HIT_W     = 16;
  localparam int CNT_W     = 16;
  localparam int PIX_W     = 32;
  localparam int SIM_W     = 16;
  localparam int PT_W      = 32;
  localparam int DCAM_W    = 4;

  // averaging arithmetic
  localparam int PROD_W    = PT_W + CNT_W + 1;
  localparam int SUM_W     = PROD_W + 1;
  localparam int DVD_W     = SUM_W;
  localparam int DIV_W     = CNT_W + 1;
  localparam int DCNT_W    = $clog2(DVD_W + 1);
  localparam int CMP_W     = PIX_W + 3;

  // command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic [VOX_W-1:0]         vox_x;
    logic [VOX_W-1:0]         vox_y;
    logic [VOX_W-1:0]         vox_z;
    logic [CAM_W-1:0]         camera_id;
    logic signed [SIM_W-1:0]  similarity;
    logic [PIX_W-1:0]         pixel_size;
    logic signed [PT_W-1:0]   obs_x;
    logic signed [PT_W-1:0]   obs_y;
    logic signed [PT_W-1:0]   obs_z;
  } vtf_req_t;

  typedef struct packed {
    logic                     status;
    logic                     occupied;
    logic [CNT_W-1:0]         sample_count;
    logic signed [PT_W-1:0]   fused_x;
    logic signed [PT_W-1:0]   fused_y;
    logic signed [PT_W-1:0]   fused_z;
    logic [PIX_W-1:0]         best_pixel_size;
    logic signed [SIM_W-1:0]  best_similarity;
    logic [DCAM_W-1:0]        distinct_cameras;
    logic [HIT_W-1:0]         camera_hits;
  } vtf_rsp_t;

  // per-voxel track record as stored
  typedef struct packed {
    logic [CNT_W-1:0]         cnt;
    logic [PIX_W-1:0]         minp;
    logic signed [SIM_W-1:0]  mins;
    logic signed [PT_W-1:0]   px;
    logic signed [PT_W-1:0]   py;
    logic signed [PT_W-1:0]   pz;
    logic [LEN_W-1:0]         len;
  } vtf_rec_t;

  localparam int REC_W = $bits(vtf_rec_t);

  // one camera list entry
  typedef struct packed {
    logic [CAM_W-1:0]         cam;
    logic [HIT_W-1:0]         hits;
  } vtf_ent_t;

  localparam int ENT_W = $bits(vtf_ent_t);

  // datapath commands
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_LOAD,
    OP_CREATE,
    OP_SCAN_RD,
    OP_SCAN_CHK,
    OP_BUMP,
    OP_FULL,
    OP_SHIFT_RD,
    OP_SHIFT_WR,
    OP_INSERT,
    OP_FUSE,
    OP_MUL,
    OP_DIV_START,
    OP_DIV_END,
    OP_AVG_MIN,
    OP_WRITE,
    OP_EMIT
  } vtf_op_e;

  // datapath status
  typedef struct packed {
    logic ok;
    logic is_read;
    logic vvalid;
    logic scan_done;
    logic found;
    logic full;
    logic shift_more;
    logic fuse_rep;
    logic fuse_avg;
    logic div_done;
    logic coord_last;
    logic clr_last;
    logic out_busy;
  } vtf_st_t;

endpackage

// ----- src/vtf_if.sv -----
interface vtf_req_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [vtf_pkg::VOX_W-1:0]         vox_x;
  logic [vtf_pkg::VOX_W-1:0]         vox_y;
  logic [vtf_pkg::VOX_W-1:0]         vox_z;
  logic [vtf_pkg::CAM_W-1:0]         camera_id;
  logic signed [vtf_pkg::SIM_W-1:0]  similarity;
  logic [vtf_pkg::PIX_W-1:0]         pixel_size;
  logic signed [vtf_pkg::PT_W-1:0]   obs_x;
  logic signed [vtf_pkg::PT_W-1:0]   obs_y;
  logic signed [vtf_pkg::PT_W-1:0]   obs_z;

  modport source (
    output valid, cmd, vox_x, vox_y, vox_z, camera_id, similarity, pixel_size,
           obs_x, obs_y, obs_z,
    input  ready
  );
  modport sink (
    input  valid, cmd, vox_x, vox_y, vox_z, camera_id, similarity, pixel_size,
           obs_x, obs_y, obs_z,
    output ready
  );
endinterface

interface vtf_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              status;
  logic                              occupied;
  logic [vtf_pkg::CNT_W-1:0]         sample_count;
  logic signed [vtf_pkg::PT_W-1:0]   fused_x;
  logic signed [vtf_pkg::PT_W-1:0]   fused_y;
  logic signed [vtf_pkg::PT_W-1:0]   fused_z;
  logic [vtf_pkg::PIX_W-1:0]         best_pixel_size;
  logic signed [vtf_pkg::SIM_W-1:0]  best_similarity;
  logic [vtf_pkg::DCAM_W-1:0]        distinct_cameras;
  logic [vtf_pkg::HIT_W-1:0]         camera_hits;

  modport source (
    output valid, status, occupied, sample_count, fused_x, fused_y, fused_z,
           best_pixel_size, best_similarity, distinct_cameras, camera_hits,
    input  ready
  );
  modport sink (
    input  valid, status, occupied, sample_count, fused_x, fused_y, fused_z,
           best_pixel_size, best_similarity, distinct_cameras, camera_hits,
    output ready
  );
endinterface

// ----- src/vtf_ram.sv -----
module vtf_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- src/vtf_div.sv -----
module vtf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [vtf_pkg::DVD_W-1:0]  dividend_i,
  input  logic [vtf_pkg::DIV_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [vtf_pkg::DVD_W-1:0]  quot_o
);
  import vtf_pkg::*;

  logic [DIV_W-1:0]  rem_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DIV_W-1:0]  dsr_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DIV_W:0]    shifted;
  logic              take;

  // restoring step, one quotient bit per cycle
  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign take    = shifted >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DCNT_W'(DVD_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= take ? DIV_W'(shifted - {1'b0, dsr_q}) : DIV_W'(shifted);
      quo_q <= {quo_q[DVD_W-2:0], take};
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quo_q;

endmodule

// ----- src/vtf_ctrl.sv -----
module vtf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  vtf_pkg::vtf_st_t  st_i,
  output vtf_pkg::vtf_op_e  op_o
);
  import vtf_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD, S_LOAD, S_SCAN, S_SCHK, S_POST, S_CREATE,
    S_SHRD, S_SHWR, S_INS, S_FUSE, S_MUL, S_DSTART, S_DWAIT, S_DEND,
    S_AVG, S_WRITE, S_EMIT
  } state_e;

  state_e state_q, state_d;

  // sequencing and command decode
  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      S_CLEAR: begin
        op_o = OP_CLEAR;
        if (st_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) begin
          op_o    = OP_ACCEPT;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = st_i.ok ? S_LOAD : S_EMIT;
      end
      S_LOAD: begin
        op_o    = OP_LOAD;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (!st_i.vvalid) begin
          state_d = st_i.is_read ? S_EMIT : S_CREATE;
        end else if (st_i.scan_done) begin
          state_d = S_POST;
        end else begin
          op_o    = OP_SCAN_RD;
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        op_o    = OP_SCAN_CHK;
        state_d = S_SCAN;
      end
      S_POST: begin
        if (st_i.is_read) begin
          state_d = S_EMIT;
        end else if (st_i.found) begin
          op_o    = OP_BUMP;
          state_d = S_FUSE;
        end else if (st_i.full) begin
          op_o    = OP_FULL;
          state_d = S_FUSE;
        end else begin
          state_d = S_SHRD;
        end
      end
      S_CREATE: begin
        op_o    = OP_CREATE;
        state_d = S_WRITE;
      end
      S_SHRD: begin
        if (st_i.shift_more) begin
          op_o    = OP_SHIFT_RD;
          state_d = S_SHWR;
        end else begin
          state_d = S_INS;
        end
      end
      S_SHWR: begin
        op_o    = OP_SHIFT_WR;
        state_d = S_SHRD;
      end
      S_INS: begin
        op_o    = OP_INSERT;
        state_d = S_FUSE;
      end
      S_FUSE: begin
        op_o    = OP_FUSE;
        state_d = (st_i.fuse_avg && !st_i.fuse_rep) ? S_MUL : S_WRITE;
      end
      S_MUL: begin
        op_o    = OP_MUL;
        state_d = S_DSTART;
      end
      S_DSTART: begin
        op_o    = OP_DIV_START;
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (st_i.div_done) state_d = S_DEND;
      end
      S_DEND: begin
        op_o    = OP_DIV_END;
        state_d = st_i.coord_last ? S_AVG : S_MUL;
      end
      S_AVG: begin
        op_o    = OP_AVG_MIN;
        state_d = S_WRITE;
      end
      S_WRITE: begin
        op_o    = OP_WRITE;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!st_i.out_busy) begin
          op_o    = OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = state_q == S_IDLE;

endmodule

// ----- src/vtf_dp.sv -----
module vtf_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vtf_pkg::vtf_op_e  op_i,
  output vtf_pkg::vtf_st_t  st_o,
  input  vtf_pkg::vtf_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output vtf_pkg::vtf_rsp_t rsp_o
);
  import vtf_pkg::*;

  // request
  logic                     cmd_q;
  logic                     ok_q;
  logic [VOX_AW-1:0]        v_q;
  logic [CAM_W-1:0]         cam_q;
  logic signed [SIM_W-1:0]  sim_q;
  logic [PIX_W-1:0]         pix_q;
  logic signed [PT_W-1:0]   obs_q [3];

  // working record
  logic                     valid_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [PIX_W-1:0]         minp_q;
  logic signed [SIM_W-1:0]  mins_q;
  logic signed [PT_W-1:0]   pt_q [3];
  logic [LEN_W-1:0]         len_q;

  // list walk and fusion
  logic [LEN_W-1:0]         idx_q;
  logic [LEN_W-1:0]         sh_q;
  logic                     found_q;
  logic                     stop_q;
  logic [HIT_W-1:0]         hits_q;
  logic                     status_q;
  logic [1:0]               coord_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     neg_q;

  // control
  logic [VOX_AW-1:0]        clr_q;
  logic                     rsp_valid_q;
  vtf_rsp_t                 rsp_q;

  logic                     valid_rd;
  vtf_rec_t                 rec_rd;
  vtf_rec_t                 rec_wr;
  vtf_ent_t                 ent_rd;
  vtf_ent_t                 ent_wr;
  logic                     list_we;
  logic [LIST_AW-1:0]       list_waddr;
  logic [LIST_AW-1:0]       list_raddr;
  logic [HIT_W-1:0]         hits_inc;
  logic [CMP_W-1:0]         p5;
  logic [CMP_W-1:0]         m4;
  logic [CMP_W-1:0]         m6;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [SUM_W-1:0]  sum;
  logic [DVD_W-1:0]         mag;
  logic [DIV_W-1:0]         dsr;
  logic                     div_busy;
  logic [DVD_W-1:0]         quot;
  logic [PT_W-1:0]          q32;
  logic                     ok_d;
  logic [VOX_AW-1:0]        v_d;

  // voxel address from the grid indices
  assign ok_d = (int'(req_i.vox_x) < GRID) && (int'(req_i.vox_y) < GRID) &&
                (int'(req_i.vox_z) < GRID);
  assign v_d  = VOX_AW'((int'(req_i.vox_x) * GRID + int'(req_i.vox_y)) * GRID +
                        int'(req_i.vox_z));

  // memories
  vtf_ram #(.W(1), .D(NVOX)) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (op_i == OP_CLEAR || op_i == OP_WRITE),
    .waddr_i (op_i == OP_CLEAR ? clr_q : v_q),
    .wdata_i (op_i == OP_WRITE),
    .raddr_i (v_q),
    .rdata_o (valid_rd)
  );

  assign rec_wr = '{cnt: cnt_q, minp: minp_q, mins: mins_q, px: pt_q[0], py: pt_q[1],
                    pz: pt_q[2], len: len_q};

  vtf_ram #(.W(REC_W), .D(NVOX)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (op_i == OP_WRITE),
    .waddr_i (v_q),
    .wdata_i (rec_wr),
    .raddr_i (v_q),
    .rdata_o (rec_rd)
  );

  assign hits_inc = (hits_q == '1) ? hits_q : hits_q + 1'b1;

  // list write and read port selection
  always_comb begin
    list_we    = 1'b0;
    list_waddr = {v_q, SLOT_W'(idx_q)};
    ent_wr     = '{cam: cam_q, hits: HIT_W'(1)};
    case (op_i)
      OP_CREATE: begin
        list_we    = 1'b1;
        list_waddr = {v_q, SLOT_W'(0)};
      end
      OP_BUMP: begin
        list_we = 1'b1;
        ent_wr  = '{cam: cam_q, hits: hits_inc};
      end
      OP_SHIFT_WR: begin
        list_we    = 1'b1;
        list_waddr = {v_q, SLOT_W'(sh_q)};
        ent_wr     = ent_rd;
      end
      OP_INSERT: begin
        list_we = 1'b1;
      end
      default: begin
        list_we = 1'b0;
      end
    endcase
  end

  assign list_raddr = (op_i == OP_SHIFT_RD) ? {v_q, SLOT_W'(sh_q - 1'b1)}
                                            : {v_q, SLOT_W'(idx_q)};

  vtf_ram #(.W(ENT_W), .D(NLIST)) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (ent_wr),
    .raddr_i (list_raddr),
    .rdata_o (ent_rd)
  );

  // pixel size thresholds: 5p < 4m replaces, otherwise 5p < 6m averages
  assign p5 = CMP_W'(pix_q) * CMP_W'(5);
  assign m4 = CMP_W'(minp_q) << 2;
  assign m6 = m4 + (CMP_W'(minp_q) << 1);

  // averaging: point * count + obs, then divide by count + 1
  assign prod_d = PROD_W'(pt_q[coord_q]) * PROD_W'($signed({1'b0, cnt_q}));
  assign sum    = SUM_W'(prod_q) + SUM_W'(obs_q[coord_q]);
  assign mag    = sum[SUM_W-1] ? DVD_W'(-sum) : DVD_W'(sum);
  assign dsr    = DIV_W'({1'b0, cnt_q}) + 1'b1;
  assign q32    = PT_W'(quot);

  vtf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (op_i == OP_DIV_START),
    .dividend_i (mag),
    .divisor_i  (dsr),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // working registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_ACCEPT: begin
        cmd_q    <= req_i.cmd;
        ok_q     <= ok_d;
        v_q      <= ok_d ? v_d : '0;
        cam_q    <= req_i.camera_id;
        sim_q    <= req_i.similarity;
        pix_q    <= req_i.pixel_size;
        obs_q[0] <= req_i.obs_x;
        obs_q[1] <= req_i.obs_y;
        obs_q[2] <= req_i.obs_z;
        valid_q  <= 1'b0;
        status_q <= 1'b0;
        hits_q   <= '0;
      end
      OP_LOAD: begin
        valid_q  <= valid_rd;
        cnt_q    <= rec_rd.cnt;
        minp_q   <= rec_rd.minp;
        mins_q   <= rec_rd.mins;
        pt_q[0]  <= rec_rd.px;
        pt_q[1]  <= rec_rd.py;
        pt_q[2]  <= rec_rd.pz;
        len_q    <= rec_rd.len;
        sh_q     <= rec_rd.len;
        idx_q    <= '0;
        found_q  <= 1'b0;
        stop_q   <= 1'b0;
        coord_q  <= '0;
      end
      OP_CREATE: begin
        valid_q  <= 1'b1;
        cnt_q    <= CNT_W'(1);
        minp_q   <= pix_q;
        mins_q   <= sim_q;
        pt_q[0]  <= obs_q[0];
        pt_q[1]  <= obs_q[1];
        pt_q[2]  <= obs_q[2];
        len_q    <= LEN_W'(1);
        hits_q   <= HIT_W'(1);
      end
      OP_SCAN_CHK: begin
        if (ent_rd.cam == cam_q) begin
          found_q <= 1'b1;
          stop_q  <= 1'b1;
          hits_q  <= ent_rd.hits;
        end else if (ent_rd.cam > cam_q) begin
          stop_q  <= 1'b1;
        end else begin
          idx_q   <= idx_q + 1'b1;
        end
      end
      OP_BUMP: begin
        hits_q <= hits_inc;
      end
      OP_FULL: begin
        status_q <= 1'b1;
      end
      OP_SHIFT_WR: begin
        sh_q <= sh_q - 1'b1;
      end
      OP_INSERT: begin
        len_q  <= len_q + 1'b1;
        hits_q <= HIT_W'(1);
      end
      OP_FUSE: begin
        if (p5 < m4) begin
          pt_q[0] <= obs_q[0];
          pt_q[1] <= obs_q[1];
          pt_q[2] <= obs_q[2];
          minp_q  <= pix_q;
          mins_q  <= sim_q;
          cnt_q   <= CNT_W'(1);
        end
      end
      OP_MUL: begin
        prod_q <= prod_d;
      end
      OP_DIV_START: begin
        neg_q <= sum[SUM_W-1];
      end
      OP_DIV_END: begin
        pt_q[coord_q] <= neg_q ? -$signed(q32) : $signed(q32);
        coord_q       <= coord_q + 1'b1;
      end
      OP_AVG_MIN: begin
        if (pix_q < minp_q) minp_q <= pix_q;
        if (sim_q < mins_q) mins_q <= sim_q;
        if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
      end
      OP_EMIT: begin
        rsp_q.status           <= status_q;
        rsp_q.occupied         <= valid_q;
        rsp_q.sample_count     <= valid_q ? cnt_q : '0;
        rsp_q.fused_x          <= valid_q ? pt_q[0] : '0;
        rsp_q.fused_y          <= valid_q ? pt_q[1] : '0;
        rsp_q.fused_z          <= valid_q ? pt_q[2] : '0;
        rsp_q.best_pixel_size  <= valid_q ? minp_q : '0;
        rsp_q.best_similarity  <= valid_q ? mins_q : '0;
        rsp_q.distinct_cameras <= valid_q ? DCAM_W'(len_q) : '0;
        rsp_q.camera_hits      <= valid_q ? hits_q : '0;
      end
      default: begin
        cmd_q <= cmd_q;
      end
    endcase
  end

  // clear sweep counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (op_i == OP_CLEAR) clr_q <= clr_q + 1'b1;
      if (op_i == OP_EMIT) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // status to the controller
  assign st_o.ok         = ok_q;
  assign st_o.is_read    = cmd_q == CMD_READ;
  assign st_o.vvalid     = valid_q;
  assign st_o.scan_done  = stop_q || (idx_q >= len_q);
  assign st_o.found      = found_q;
  assign st_o.full       = len_q >= LEN_W'(MAX_CAMS);
  assign st_o.shift_more = sh_q > idx_q;
  assign st_o.fuse_rep   = p5 < m4;
  assign st_o.fuse_avg   = p5 < m6;
  assign st_o.div_done   = !div_busy;
  assign st_o.coord_last = coord_q == 2'd2;
  assign st_o.clr_last   = &clr_q;
  assign st_o.out_busy   = rsp_valid_q;

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ----- src/voxel_track_fusion_top.sv -----
// one request at a time; a read walks the camera list of its voxel entry by entry
// an add also moves list entries on insertion, and averaging runs each coordinate
// through the shared divider, which retires one quotient bit per cycle over 50 bits
// the camera list memory has one read port, so the list walk reads one entry at a time
// after reset a clearing pass over all 4096 voxels empties the voxel table; no request is
// taken during it and the result register comes up empty
module voxel_track_fusion_top (
  input logic       clk_i,
  input logic       rst_ni,
  vtf_req_if.sink   req_i,
  vtf_rsp_if.source rsp_o
);
  import vtf_pkg::*;

  vtf_op_e  op;
  vtf_st_t  st;
  vtf_req_t req;
  vtf_rsp_t rsp;
  logic     req_ready;
  logic     rsp_valid;

  // pack request payload
  assign req = '{cmd: req_i.cmd, vox_x: req_i.vox_x, vox_y: req_i.vox_y,
                 vox_z: req_i.vox_z, camera_id: req_i.camera_id,
                 similarity: req_i.similarity, pixel_size: req_i.pixel_size,
                 obs_x: req_i.obs_x, obs_y: req_i.obs_y, obs_z: req_i.obs_z};

  vtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .st_i        (st),
    .op_o        (op)
  );

  vtf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .st_o        (st),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp)
  );

  assign req_i.ready            = req_ready;
  assign rsp_o.valid            = rsp_valid;
  assign rsp_o.status           = rsp.status;
  assign rsp_o.occupied         = rsp.occupied;
  assign rsp_o.sample_count     = rsp.sample_count;
  assign rsp_o.fused_x          = rsp.fused_x;
  assign rsp_o.fused_y          = rsp.fused_y;
  assign rsp_o.fused_z          = rsp.fused_z;
  assign rsp_o.best_pixel_size  = rsp.best_pixel_size;
  assign rsp_o.best_similarity  = rsp.best_similarity;
  assign rsp_o.distinct_cameras = rsp.distinct_cameras;
  assign rsp_o.camera_hits      = rsp.camera_hits;

  // one request in flight at a time
  a_single_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while another is in flight");

  // a dropped camera implies an occupied voxel
  a_drop_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status |-> rsp_o.occupied)
    else $error("camera dropped on an empty voxel");

  // empty voxel reports zeros
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.occupied |->
      rsp_o.sample_count == '0 && rsp_o.camera_hits == '0)
    else $error("empty voxel with nonzero record");

  // an occupied voxel has a nonempty count
  a_occ_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.occupied |-> rsp_o.sample_count != '0)
    else $error("occupied voxel with zero sample count");

endmodule
